// ===== hw/rtl/sbfd_pkg.sv =====
// Package for the SBUS frame decoder: beat types, frame type, register indexes
// and decoder constants. No dependencies.
package sbfd_pkg;

  localparam int unsigned FRAME_LEN     = 25;
  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned CHAN_W        = 11;
  localparam int unsigned CHAN_BITS_W   = 176;  // bytes 1 to 22
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam int unsigned CFG_DATA_W    = 11;

  localparam logic [7:0] FRAME_HEAD     = 8'h0F;
  localparam logic [7:0] FRAME_TAIL     = 8'h00;
  localparam logic [4:0] COUNT_LAST     = 5'd24;  // count before the 25th byte
  localparam logic [4:0] COUNT_FULL     = 5'd25;
  localparam logic [4:0] COUNT_OVERFLOW = 5'd26;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE   = 8'd3;

  localparam logic [10:0] RESET_WINDOW_LOW  = 11'd364;
  localparam logic [10:0] RESET_WINDOW_HIGH = 11'd1684;
  localparam logic [10:0] RESET_CENTER      = 11'd1024;
  localparam logic [9:0]  RESET_DEAD_ZONE   = 10'd10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         channel_number;
    logic signed [11:0] chan_value;
    logic [7:0]         flags_byte;
    logic               link_alive;
    logic               last_channel;
  } out_item_t;

  // Accepted frame handed from front to back
  typedef struct packed {
    logic [7:0]             flags;
    logic [CHAN_BITS_W-1:0] chan_bits;
  } frame_t;

  // Stick conditioning settings
  typedef struct packed {
    logic [10:0] window_low;
    logic [10:0] window_high;
    logic [10:0] center_value;
    logic [9:0]  dead_zone;
  } cond_cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== hw/rtl/sbfd_fifo.sv =====
// Small register queue used between decoder stages and at the result side.
// Depends on nothing; first-word data is shown combinationally.
module sbfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store beats
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sbfd_front.sv =====
// Front end: collects received bytes into the frame buffer and checks length,
// header and tail. Depends on sbfd_pkg.
module sbfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sbfd_pkg::in_item_t item,
  output logic              frame_push,
  output sbfd_pkg::frame_t  frame
);

  logic [7:0] frame_buf [24];
  logic [4:0] byte_count;
  logic       storing;

  assign storing = (byte_count < sbfd_pkg::COUNT_FULL);

  // Store the byte at the current position
  always_ff @(posedge clk) begin
    if (accept && (byte_count < sbfd_pkg::COUNT_LAST)) begin
      frame_buf[byte_count] <= item.rx_byte;
    end
  end

  // Count bytes; saturate past a full frame, clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (item.frame_end) begin
        byte_count <= '0;
      end else if (storing) begin
        byte_count <= byte_count + 1'b1;
      end else begin
        byte_count <= sbfd_pkg::COUNT_OVERFLOW;
      end
    end
  end

  // Closing byte is byte 24 itself, so check it on the wire
  assign frame_push = accept && item.frame_end &&
                      (byte_count == sbfd_pkg::COUNT_LAST) &&
                      (frame_buf[0] == sbfd_pkg::FRAME_HEAD) &&
                      (item.rx_byte == sbfd_pkg::FRAME_TAIL);

  // Pack bytes 1 to 22 little-endian, byte 23 as flags
  always_comb begin
    frame.flags = frame_buf[23];
    for (int i = 1; i <= 22; i++) begin
      frame.chan_bits[8*(i-1) +: 8] = frame_buf[i];
    end
  end

endmodule

// ===== hw/rtl/sbfd_back.sv =====
// Back end: walks a queued frame one channel per cycle while the result queue has room,
// conditions the stick channels and writes results. Depends on sbfd_pkg.
module sbfd_back (
  input  logic                clk,
  input  logic                rst,
  input  sbfd_pkg::cond_cfg_t cfg,
  input  logic                frame_avail,
  input  sbfd_pkg::frame_t    frame,
  output logic                frame_pop,
  input  logic                res_full,
  output logic                res_push,
  output sbfd_pkg::out_item_t res
);

  sbfd_pkg::back_state_t state;
  sbfd_pkg::back_state_t state_next;

  logic [sbfd_pkg::CHAN_BITS_W-1:0] chan_bits;
  logic [7:0]                       flags;
  logic [3:0]                       ch_idx;
  logic                             last;
  logic                             load;

  logic [10:0]        raw;
  logic               in_window;
  logic signed [11:0] diff;
  logic signed [11:0] centred;
  logic [11:0]        mag;
  logic signed [11:0] value;

  assign last = (ch_idx == 4'(sbfd_pkg::NUM_CHANNELS - 1));

  // Sequence frames and emit one beat per free slot
  always_comb begin
    state_next = state;
    res_push   = 1'b0;
    load       = 1'b0;
    case (state)
      sbfd_pkg::BK_IDLE: begin
        if (frame_avail) begin
          load       = 1'b1;
          state_next = sbfd_pkg::BK_RUN;
        end
      end
      sbfd_pkg::BK_RUN: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (last) begin
            load       = frame_avail;
            state_next = frame_avail ? sbfd_pkg::BK_RUN : sbfd_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = sbfd_pkg::BK_IDLE;
      end
    endcase
  end

  assign frame_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbfd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a frame or shift to the next channel
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx <= '0;
    end else if (load) begin
      ch_idx <= '0;
    end else if (res_push) begin
      ch_idx <= ch_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chan_bits <= frame.chan_bits;
      flags     <= frame.flags;
    end else if (res_push) begin
      chan_bits <= chan_bits >> sbfd_pkg::CHAN_W;
    end
  end

  // Condition: window, centre, dead zone
  always_comb begin
    raw       = chan_bits[sbfd_pkg::CHAN_W-1:0];
    in_window = (raw >= cfg.window_low) && (raw <= cfg.window_high);
    diff      = $signed({1'b0, raw}) - $signed({1'b0, cfg.center_value});
    centred   = in_window ? diff : 12'sd0;
    mag       = centred[11] ? 12'(-centred) : 12'(centred);
    if (ch_idx < 4'd4) begin
      value = (mag <= {2'b00, cfg.dead_zone}) ? 12'sd0 : centred;
    end else begin
      value = $signed({1'b0, raw});
    end
  end

  assign res.channel_number = {1'b0, ch_idx} + 5'd1;
  assign res.chan_value     = value;
  assign res.flags_byte     = flags;
  assign res.link_alive     = (flags == 8'h00);
  assign res.last_channel   = last;

endmodule

// ===== hw/rtl/sbfd_frame_decoder_top_placeholder.sv =====
// Result order helper: tracks which channel the next beat leaving the back end
// should carry and flags a mismatch. Depends on sbfd_pkg.
module sbfd_order_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_push,
  input  sbfd_pkg::out_item_t res,
  output logic                order_ok
);

  logic [4:0] expect_num;

  // Track which channel the next beat should carry
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_num <= 5'd1;
    end else if (res_push) begin
      expect_num <= res.last_channel ? 5'd1 : expect_num + 5'd1;
    end
  end

  assign order_ok = !res_push || (res.channel_number == expect_num);

endmodule

// ===== hw/rtl/sbus_frame_decoder.sv =====
// SBUS frame decoder, 16 channels.
// Throughput: one byte accepted per cycle unless the frame queue is full; one result per
// cycle while results are taken. An accepted frame passes through the frame queue and
// the back end's single conditioning unit, which emits its 16 results in channel order.
// Reset (synchronous): byte count and queues clear, registers return to defaults;
// the frame buffer is not cleared.
module sbus_frame_decoder #(
  parameter int unsigned FRAME_QUEUE_DEPTH  = 2,
  parameter int unsigned RESULT_QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  sbfd_pkg::in_item_t                  rx_item,
  output logic                                empty,
  input  logic                                pop,
  output sbfd_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sbfd_pkg::cond_cfg_t cfg;
  sbfd_pkg::frame_t    fr_in;
  sbfd_pkg::frame_t    fr_out;
  sbfd_pkg::out_item_t res;
  logic                accept;
  logic                fr_push;
  logic                fr_pop;
  logic                fr_full;
  logic                fr_empty;
  logic                res_push;
  logic                res_full;
  logic                order_ok;

  assign cfg_ready = 1'b1;
  assign full      = fr_full;
  assign accept    = push && !fr_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_low   <= sbfd_pkg::RESET_WINDOW_LOW;
      cfg.window_high  <= sbfd_pkg::RESET_WINDOW_HIGH;
      cfg.center_value <= sbfd_pkg::RESET_CENTER;
      cfg.dead_zone    <= sbfd_pkg::RESET_DEAD_ZONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbfd_pkg::REG_WINDOW_LOW:  cfg.window_low   <= cfg_data;
        sbfd_pkg::REG_WINDOW_HIGH: cfg.window_high  <= cfg_data;
        sbfd_pkg::REG_CENTER:      cfg.center_value <= cfg_data;
        sbfd_pkg::REG_DEAD_ZONE:   cfg.dead_zone    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  sbfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (rx_item),
    .frame_push (fr_push),
    .frame      (fr_in)
  );

  sbfd_fifo #(
    .WIDTH ($bits(sbfd_pkg::frame_t)),
    .DEPTH (FRAME_QUEUE_DEPTH)
  ) u_frame_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_push),
    .wdata (fr_in),
    .pop   (fr_pop),
    .rdata (fr_out),
    .full  (fr_full),
    .empty (fr_empty)
  );

  sbfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_avail (!fr_empty),
    .frame       (fr_out),
    .frame_pop   (fr_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  sbfd_order_check u_order (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .order_ok (order_ok)
  );

  sbfd_fifo #(
    .WIDTH ($bits(sbfd_pkg::out_item_t)),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (result),
    .full  (res_full),
    .empty (empty)
  );

  // Checks
  a_frame_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fr_push |-> !fr_full)
    else $error("frame queue written while full");

  a_channel_order: assert property (@(posedge clk) disable iff (rst)
    order_ok)
    else $error("result beats out of channel order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_channel == (result.channel_number == 5'd16)))
    else $error("last_channel does not match channel sixteen");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// ===== dv/tb_sbus_frame_decoder.sv =====
// Self-checking testbench for sbus_frame_decoder: drives byte beats, predicts the
// 16 channel results of each accepted frame and checks every result beat in order.
// Depends on sbfd_pkg and the sbus_frame_decoder RTL only.
module tb_sbus_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfd_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 24;    // quiet margin after the last expected result is taken
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BYTES    = 20;
  localparam int unsigned MAX_FRAME_LEN  = 28;

  // Indexes the block has no register for
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t rx_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the conditioning registers
  logic [10:0] win_lo = RESET_WINDOW_LOW;
  logic [10:0] win_hi = RESET_WINDOW_HIGH;
  logic [10:0] centre = RESET_CENTER;
  logic [9:0]  dead   = RESET_DEAD_ZONE;

  // Frame collector state of the predictor
  logic [7:0] model_frame [FRAME_LEN];
  logic [4:0] model_count = '0;

  out_item_t expected_channels [$];
  logic [7:0] tx_frame [MAX_FRAME_LEN];
  int unsigned send_gap_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned stalled_cycles = 0;
  int errors = 0;

  sbus_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_item   (rx_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Window, centre and dead zone applied to one stick channel
  function automatic logic signed [11:0] shape_stick(logic [10:0] raw);
    logic [10:0] level;
    int offset;
    level = raw;
    if (raw < win_lo || raw > win_hi) level = centre;
    offset = int'(level) - int'(centre);
    if ((offset < 0 ? -offset : offset) <= int'(dead)) offset = 0;
    return offset[11:0];
  endfunction

  // Advance the collector by one byte; queue 16 channels when a good frame closes
  task automatic decode_byte(input in_item_t beat);
    logic [CHAN_BITS_W-1:0] bits;
    logic [10:0] raw;
    out_item_t chan;
    if (model_count < COUNT_FULL) begin
      model_frame[model_count] = beat.rx_byte;
      model_count = model_count + 5'd1;
    end else begin
      model_count = COUNT_OVERFLOW;
    end
    if (beat.frame_end) begin
      if (model_count == COUNT_FULL && model_frame[0] == FRAME_HEAD &&
          model_frame[FRAME_LEN-1] == FRAME_TAIL) begin
        for (int i = 0; i < 22; i++) bits[8*i +: 8] = model_frame[i+1];
        for (int n = 0; n < NUM_CHANNELS; n++) begin
          raw = bits[CHAN_W*n +: CHAN_W];
          chan.channel_number = 5'(n + 1);
          chan.chan_value     = (n < 4) ? shape_stick(raw) : {1'b0, raw};
          chan.flags_byte     = model_frame[23];
          chan.link_alive     = (model_frame[23] == 8'h00);
          chan.last_channel   = (n == NUM_CHANNELS - 1);
          expected_channels.push_back(chan);
        end
      end
      model_count = '0;
    end
  endtask

  // Offer one byte beat, idling first at random; push stays high afterwards
  task automatic send_byte(input in_item_t beat);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_item <= beat;
    do @(posedge clk); while (full);
    decode_byte(beat);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte('{rx_byte: tx_frame[i], frame_end: (i == len - 1)});
    end
  endtask

  // Hold off until every result is in and the back end has gone quiet
  task automatic wait_drained;
    push <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write beat; valid stays high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (reg_index)
      REG_WINDOW_LOW:  win_lo = value;
      REG_WINDOW_HIGH: win_hi = value;
      REG_CENTER:      centre = value;
      REG_DEAD_ZONE:   dead   = value[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [10:0] lo, input logic [10:0] hi,
                                input logic [10:0] mid, input logic [10:0] zone);
    wait_drained();
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    write_reg(REG_CENTER, mid);
    write_reg(REG_DEAD_ZONE, zone);
    // writes to indexes with no register must change nothing
    write_reg(REG_SPARE, 11'(0));
    write_reg(REG_UNUSED, 11'h7FF);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic run_random_traffic(input int budget);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      len  = FRAME_LEN;
      foreach (tx_frame[i]) tx_frame[i] = 8'($urandom);
      tx_frame[0]  = FRAME_HEAD;
      tx_frame[23] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
      tx_frame[24] = FRAME_TAIL;
      if (pick >= 70) begin
        if (pick < 78) begin
          tx_frame[0] = FRAME_HEAD ^ 8'($urandom_range(1, 255));
        end else if (pick < 86) begin
          tx_frame[24] = 8'($urandom_range(1, 255));
        end else if (pick < 93) begin
          tx_frame[0] = 8'($urandom);
          len = $urandom_range(1, FRAME_LEN - 1);
        end else begin
          len = $urandom_range(FRAME_LEN + 1, MAX_FRAME_LEN);
        end
      end
      send_frame(len);
      sent += len;
    end
  endtask

  // Good frame under reset settings: window edges, dead zone edge, raw extremes
  task automatic test_reset_defaults_frame;
    logic [CHAN_BITS_W-1:0] bits;
    logic [10:0] chans [NUM_CHANNELS];
    chans[0] = RESET_WINDOW_LOW - 11'd1;
    chans[1] = RESET_WINDOW_HIGH;
    chans[2] = RESET_CENTER + RESET_DEAD_ZONE;
    chans[3] = RESET_CENTER - RESET_DEAD_ZONE - 11'd1;
    for (int n = 4; n < NUM_CHANNELS; n++) begin
      case (n % 4)
        0: chans[n] = 11'h000;
        1: chans[n] = 11'h7FF;
        2: chans[n] = 11'h555;
        default: chans[n] = 11'h2AA;
      endcase
    end
    foreach (chans[n]) bits[CHAN_W*n +: CHAN_W] = chans[n];
    tx_frame[0] = FRAME_HEAD;
    for (int i = 0; i < 22; i++) tx_frame[i+1] = bits[8*i +: 8];
    tx_frame[23] = 8'h00;
    tx_frame[24] = FRAME_TAIL;
    send_frame(FRAME_LEN);
  endtask

  // A one-byte frame and a 26-byte frame are both dropped; the count restarts
  task automatic test_frame_length_rejects;
    tx_frame[0] = FRAME_HEAD;
    send_frame(1);
    foreach (tx_frame[i]) tx_frame[i] = 8'($urandom);
    tx_frame[0]  = FRAME_HEAD;
    tx_frame[23] = 8'hFF;
    tx_frame[24] = FRAME_TAIL;
    send_frame(FRAME_LEN + 1);
  endtask

  // Full window, zero centre and no dead zone: sticks read back raw
  task automatic test_full_range_settings;
    apply_settings(11'd0, 11'h7FF, 11'd0, 11'd0);
    run_random_traffic(PHASE_BYTES);
  endtask

  // Top centre and widest dead zone; bit 10 of the dead zone write is dropped
  task automatic test_high_centre_settings;
    apply_settings(11'd0, 11'h7FF, 11'h7FF, 11'h7FF);
    run_random_traffic(PHASE_BYTES);
  endtask

  task automatic test_random_settings;
    logic [10:0] lo;
    logic [10:0] hi;
    lo = 11'($urandom_range(0, 1023));
    hi = 11'($urandom_range(1024, 2047));
    apply_settings(lo, hi, 11'($urandom_range(lo, hi)), 11'($urandom_range(0, 63)));
    run_random_traffic(PHASE_BYTES);
  endtask

  // Low above high: every stick value falls back to centre and reads zero
  task automatic test_inverted_window;
    apply_settings(11'($urandom_range(1025, 2047)), 11'($urandom_range(0, 1023)),
                   11'($urandom), 11'($urandom));
    run_random_traffic(PHASE_BYTES);
  endtask

  // Take result beats at random and compare them with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_channels.size() == 0) begin
          $error("result beat with nothing expected: channel_number %0d",
                 result.channel_number);
          errors++;
        end else begin
          automatic out_item_t chan = expected_channels.pop_front();
          if (result.channel_number !== chan.channel_number) begin
            $error("channel_number: expected %0d, got %0d",
                   chan.channel_number, result.channel_number);
            errors++;
          end
          if (result.chan_value !== chan.chan_value) begin
            $error("chan_value: expected %0d, got %0d",
                   chan.chan_value, result.chan_value);
            errors++;
          end
          if (result.flags_byte !== chan.flags_byte) begin
            $error("flags_byte: expected 0x%02h, got 0x%02h",
                   chan.flags_byte, result.flags_byte);
            errors++;
          end
          if (result.link_alive !== chan.link_alive) begin
            $error("link_alive: expected %0b, got %0b", chan.link_alive, result.link_alive);
            errors++;
          end
          if (result.last_channel !== chan.last_channel) begin
            $error("last_channel: expected %0b, got %0b",
                   chan.last_channel, result.last_channel);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Stop the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sbus_frame_decoder failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender rarely idle, receiver often stalled
    send_gap_pct  = 6;
    pop_stall_pct = 46;
    test_reset_defaults_frame();
    test_frame_length_rejects();
    test_full_range_settings();

    // sender often idle, receiver rarely stalled
    send_gap_pct  = 46;
    pop_stall_pct = 6;
    test_high_centre_settings();

    // no idling on either side
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    test_random_settings();
    test_inverted_window();

    wait_drained();
    if (errors == 0 && expected_channels.size() == 0) begin
      $display("tb_sbus_frame_decoder passed");
    end else begin
      $display("tb_sbus_frame_decoder failed");
    end
    $finish;
  end

endmodule
